>>> rtl/core/ppu_pkg.sv
// Package for the particle pool update block: field widths, packed layouts
// of the slot word and of the stream payloads, sequencer states and codes.
// No dependencies.
package ppu_pkg;

  localparam int POS_W   = 24;
  localparam int VEL_W   = 16;
  localparam int GRAV_W  = 10;
  localparam int KILL_W  = 12;
  localparam int SLOT_W  = 9;
  localparam int HALF_W  = 3;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 10'd102;
  localparam logic [KILL_W-1:0] KILL_RESET = 12'd480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL    = 1'b1;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // One pool slot as stored in the RAM (x in the lowest bits)
  typedef struct packed {
    logic              alive;
    logic [HALF_W-1:0] half;
    logic              size_cls;
    logic [VEL_W-1:0]  vy;
    logic [VEL_W-1:0]  vx;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  x;
  } slot_word_t;

  localparam int SLOT_WORD_W = $bits(slot_word_t);

  // Input payload, last declared field in the lowest bits
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              spawn_kind;
    logic [VEL_W-1:0]  spawn_vy;
    logic [VEL_W-1:0]  spawn_vx;
    logic [POS_W-1:0]  spawn_y;
    logic [POS_W-1:0]  spawn_x;
  } in_word_t;

  localparam int IN_W       = $bits(in_word_t);
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  // Result payload, last declared field in the lowest bits
  typedef struct packed {
    logic [5:0]        sprite_size;
    logic [4:0]        sprite_src_y;
    logic [6:0]        sprite_src_x;
    logic              cur_kind;
    logic [POS_W-1:0]  cur_y;
    logic [POS_W-1:0]  cur_x;
    logic              is_alive;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
  } out_word_t;

  localparam int OUT_W       = $bits(out_word_t);
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SP_RD,
    ST_SP_CHK,
    ST_TK_RD,
    ST_TK_LD,
    ST_TK_VY,
    ST_TK_PX,
    ST_TK_PY,
    ST_TK_WR,
    ST_RD_RD,
    ST_RD_LD,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/ppu_alu.sv
// Shared saturating adder of the particle update: 24-bit signed add that
// clamps to either 24-bit or 16-bit signed range. Uses ppu_pkg.
module ppu_alu (
  input  logic [ppu_pkg::POS_W-1:0] a_i,
  input  logic [ppu_pkg::POS_W-1:0] b_i,
  input  logic                      sat16_i,
  output logic [ppu_pkg::POS_W-1:0] sum_o
);
  import ppu_pkg::*;

  localparam logic signed [POS_W:0] HI_POS = 25'sd8388607;
  localparam logic signed [POS_W:0] LO_POS = -25'sd8388608;
  localparam logic signed [POS_W:0] HI_VEL = 25'sd32767;
  localparam logic signed [POS_W:0] LO_VEL = -25'sd32768;

  logic signed [POS_W:0] sum;
  logic signed [POS_W:0] hi;
  logic signed [POS_W:0] lo;

  // Add with one guard bit, then clamp to the selected range
  assign sum = {a_i[POS_W-1], a_i} + {b_i[POS_W-1], b_i};
  assign hi  = sat16_i ? HI_VEL : HI_POS;
  assign lo  = sat16_i ? LO_VEL : LO_POS;

  always_comb begin
    if (sum > hi) begin
      sum_o = hi[POS_W-1:0];
    end else if (sum < lo) begin
      sum_o = lo[POS_W-1:0];
    end else begin
      sum_o = sum[POS_W-1:0];
    end
  end

endmodule

>>> rtl/core/particle_pool_update.sv
// Particle pool update: spawn, tick and read items over a pool held in one RAM.
// Spawn reads and checks slots in turn, up to POOL_SIZE; tick reads and loads
// each slot, updating and writing back live ones; read reads and loads a slot.
// One item at a time; the RAM read port and the shared adder set the rate.
// Reset: a clearing pass writes every slot dead; no items are taken meanwhile.
// Uses ppu_pkg, ppu_ram and ppu_alu.
module particle_pool_update #(
  parameter int POOL_SIZE = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Fields from bit 0: spawn_x, spawn_y, spawn_vx, spawn_vy, spawn_kind,
  // slot_index
  input  logic [ppu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: kind
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: accepted, slot, is_alive, cur_x, cur_y, cur_kind,
  // sprite_src_x, sprite_src_y, sprite_size
  output logic [ppu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppu_pkg::CFG_W-1:0]          cfg_data_i
);
  import ppu_pkg::*;

  localparam int IW = $clog2(POOL_SIZE);
  localparam int EW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

  state_e            state_q, state_d;
  logic [IW-1:0]     addr_q, addr_d;
  slot_word_t        work_q, work_d;
  out_word_t         res_q, res_d;
  out_word_t         m_data_q, m_data_d;
  logic              m_valid_q, m_valid_d;
  logic [GRAV_W-1:0] grav_q;
  logic [KILL_W-1:0] kill_q;

  in_word_t          in_word;
  kind_e             in_kind;
  logic              in_acc;
  logic [EW-1:0]     slot_ext;
  logic              slot_in_range;
  logic [EW-1:0]     addr_ext;
  logic              last;

  logic              ram_we;
  logic [SLOT_WORD_W-1:0] ram_wdata;
  logic [SLOT_WORD_W-1:0] ram_rdata;
  slot_word_t        rd_word;

  logic [POS_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sat16;
  logic              killed;
  logic              big;
  logic [1:0]        frame;

  // Decode the request
  assign in_word       = in_word_t'(s_axis_tdata[IN_W-1:0]);
  assign in_kind       = kind_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_ext      = EW'(in_word.slot_index);
  assign slot_in_range = (32'(slot_ext) < POOL_SIZE);
  assign addr_ext      = EW'(addr_q);
  assign last          = (addr_q == LAST);
  assign rd_word       = slot_word_t'(ram_rdata);

  // Kill test on the moved y, Q8 against the whole-pixel line
  assign killed = $signed({work_q.y[POS_W-1], work_q.y}) >
                  $signed({5'b0, kill_q, 8'h00});

  // Sprite rectangle of the slot being read
  assign big   = rd_word.size_cls;
  assign frame = rd_word.half[HALF_W-1:1];

  ppu_ram #(
    .WIDTH (SLOT_WORD_W),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  ppu_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sat16_i (alu_sat16),
    .sum_o   (alu_sum)
  );

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAV_RESET;
      kill_q <= KILL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRAVITY: grav_q <= cfg_data_i[GRAV_W-1:0];
        REG_KILL:    kill_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_SPAWN: state_d = ST_SP_RD;
            KIND_TICK:  state_d = ST_TK_RD;
            KIND_READ:  state_d = slot_in_range ? ST_RD_RD : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SP_RD:  state_d = ST_SP_CHK;
      ST_SP_CHK: state_d = (!rd_word.alive || last) ? ST_DONE : ST_SP_RD;
      ST_TK_RD:  state_d = ST_TK_LD;
      ST_TK_LD: begin
        if (rd_word.alive) begin
          state_d = ST_TK_VY;
        end else begin
          state_d = last ? ST_DONE : ST_TK_RD;
        end
      end
      ST_TK_VY:  state_d = ST_TK_PX;
      ST_TK_PX:  state_d = ST_TK_PY;
      ST_TK_PY:  state_d = ST_TK_WR;
      ST_TK_WR:  state_d = last ? ST_DONE : ST_TK_RD;
      ST_RD_RD:  state_d = ST_RD_LD;
      ST_RD_LD:  state_d = ST_DONE;
      ST_DONE:   if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    addr_d    = addr_q;
    work_d    = work_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_wdata = work_q;
    alu_a     = work_q.x;
    alu_b     = {{(POS_W-VEL_W){work_q.vx[VEL_W-1]}}, work_q.vx};
    alu_sat16 = 1'b0;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    // Drop a result the sink has taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (!last) addr_d = addr_q + IW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (in_kind)
            KIND_SPAWN: begin
              addr_d          = '0;
              work_d.alive    = 1'b1;
              work_d.half     = '0;
              work_d.size_cls = in_word.spawn_kind;
              work_d.vy       = in_word.spawn_vy;
              work_d.vx       = in_word.spawn_vx;
              work_d.y        = in_word.spawn_y;
              work_d.x        = in_word.spawn_x;
            end
            KIND_TICK: addr_d = '0;
            KIND_READ: begin
              addr_d     = slot_ext[IW-1:0];
              res_d.slot = in_word.slot_index;
            end
            default: ;
          endcase
        end
      end
      ST_SP_CHK: begin
        // Claim the first dead slot, or report a full pool
        if (!rd_word.alive) begin
          ram_we         = 1'b1;
          res_d.accepted = 1'b1;
          res_d.slot     = addr_ext[SLOT_W-1:0];
        end else if (!last) begin
          addr_d = addr_q + IW'(1);
        end
      end
      ST_TK_LD: begin
        if (rd_word.alive) begin
          work_d = rd_word;
        end else if (!last) begin
          addr_d = addr_q + IW'(1);
        end
      end
      ST_TK_VY: begin
        alu_a     = {{(POS_W-VEL_W){work_q.vy[VEL_W-1]}}, work_q.vy};
        alu_b     = {{(POS_W-GRAV_W){1'b0}}, grav_q};
        alu_sat16 = 1'b1;
        work_d.vy = alu_sum[VEL_W-1:0];
      end
      ST_TK_PX: begin
        work_d.x = alu_sum;
      end
      ST_TK_PY: begin
        alu_a    = work_q.y;
        alu_b    = {{(POS_W-VEL_W){work_q.vy[VEL_W-1]}}, work_q.vy};
        work_d.y = alu_sum;
      end
      ST_TK_WR: begin
        // Write back, step the frame, kill below the line
        ram_we          = 1'b1;
        ram_wdata       = work_q;
        ram_wdata[SLOT_WORD_W-1] = !killed;
        ram_wdata[SLOT_WORD_W-2 -: HALF_W] = work_q.half + HALF_W'(1);
        if (!last) addr_d = addr_q + IW'(1);
      end
      ST_RD_LD: begin
        res_d.is_alive     = rd_word.alive;
        res_d.cur_x        = rd_word.x;
        res_d.cur_y        = rd_word.y;
        res_d.cur_kind     = big;
        res_d.sprite_src_x = big ? {frame, 5'b0} : {1'b0, frame, 4'b0};
        res_d.sprite_src_y = big ? 5'd16 : 5'd0;
        res_d.sprite_size  = big ? 6'd32 : 6'd16;
      end
      ST_DONE: begin
        // Move the result into the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      addr_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

  // RAM is written only by the clearing pass, a spawn claim or a tick write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_SP_CHK || state_q == ST_TK_WR))
    else $error("RAM write outside a writing state");

  // A dead slot found by the scan ends the spawn with an accepted result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SP_CHK && !rd_word.alive) |=> (state_q == ST_DONE && res_q.accepted))
    else $error("spawn did not claim the free slot");

  // An accepted spawn names a slot inside the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.accepted) |-> (32'(m_data_q.slot) < POOL_SIZE))
    else $error("spawn reported a slot beyond the pool");

  // No result is presented during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !m_valid_q)
    else $error("result produced during the clearing pass");

endmodule

>>> bench/particle_pool_update_checker.sv
// Checker for the particle pool update block: watches the request, result and
// register channels, keeps its own copy of the pool and compares every result.
// Depends on ppu_pkg.
`timescale 1ns / 100ps

module particle_pool_update_checker #(
  parameter int POOL_SIZE = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ppu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [ppu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppu_pkg::CFG_W-1:0]       cfg_data_i,
  output logic [31:0]                     errors_o,
  output logic [31:0]                     pending_o,
  output logic [31:0]                     written_o
);
  import ppu_pkg::*;

  // Shadow pool
  logic signed [POS_W-1:0] pos_x_mem [POOL_SIZE];
  logic signed [POS_W-1:0] pos_y_mem [POOL_SIZE];
  logic signed [VEL_W-1:0] vel_x_mem [POOL_SIZE];
  logic signed [VEL_W-1:0] vel_y_mem [POOL_SIZE];
  logic                    live_mem  [POOL_SIZE];
  logic                    large_mem [POOL_SIZE];
  logic [HALF_W-1:0]       half_mem  [POOL_SIZE];
  logic [GRAV_W-1:0]       gravity;
  logic [KILL_W-1:0]       kill_line;

  out_word_t due_results [$];
  int        mismatches = 0;
  int        due_count = 0;
  // one past the highest slot ever spawned into; slots below it hold data
  int        written = 0;

  assign errors_o  = mismatches;
  assign pending_o = due_count;
  assign written_o = written;

  task automatic report_mismatch(input string msg);
    $display("%0t ns pool check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Apply one request to the shadow pool and queue the result it must produce
  task automatic apply_request(input kind_e kind, input in_word_t w);
    out_word_t want;
    int        idx;
    int        frame;
    int        size;
    longint    kill_q8;
    want = '0;
    case (kind)
      KIND_SPAWN: begin
        idx = 0;
        while (idx < POOL_SIZE && live_mem[idx]) idx++;
        if (idx < POOL_SIZE) begin
          live_mem[idx]  = 1'b1;
          pos_x_mem[idx] = w.spawn_x;
          pos_y_mem[idx] = w.spawn_y;
          vel_x_mem[idx] = w.spawn_vx;
          vel_y_mem[idx] = w.spawn_vy;
          large_mem[idx] = w.spawn_kind;
          half_mem[idx]  = '0;
          want.accepted  = 1'b1;
          want.slot      = SLOT_W'(idx);
          if (idx + 1 > written) written = idx + 1;
        end
      end
      KIND_TICK: begin
        kill_q8 = longint'(kill_line) * 256;
        for (idx = 0; idx < POOL_SIZE; idx++) begin
          if (live_mem[idx]) begin
            vel_y_mem[idx] = VEL_W'(clamp_signed(longint'(vel_y_mem[idx])
                                                 + longint'(gravity), VEL_W));
            pos_x_mem[idx] = POS_W'(clamp_signed(longint'(pos_x_mem[idx])
                                                 + longint'(vel_x_mem[idx]), POS_W));
            pos_y_mem[idx] = POS_W'(clamp_signed(longint'(pos_y_mem[idx])
                                                 + longint'(vel_y_mem[idx]), POS_W));
            half_mem[idx]  = half_mem[idx] + 1'b1;
            if (longint'(pos_y_mem[idx]) > kill_q8) live_mem[idx] = 1'b0;
          end
        end
      end
      KIND_READ: begin
        idx = int'(w.slot_index);
        want.slot = w.slot_index;
        if (idx < POOL_SIZE) begin
          size  = large_mem[idx] ? 32 : 16;
          frame = int'(half_mem[idx] >> 1);
          want.is_alive     = live_mem[idx];
          want.cur_x        = pos_x_mem[idx];
          want.cur_y        = pos_y_mem[idx];
          want.cur_kind     = large_mem[idx];
          want.sprite_src_x = 7'(frame * size);
          want.sprite_src_y = large_mem[idx] ? 5'd16 : 5'd0;
          want.sprite_size  = 6'(size);
        end
      end
      default: ;
    endcase
    due_results.push_back(want);
  endtask

  task automatic compare_result(input out_word_t got);
    out_word_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no request pending", got));
    end else begin
      want = due_results.pop_front();
      check_field("accepted", 32'(got.accepted), 32'(want.accepted));
      check_field("slot", 32'(got.slot), 32'(want.slot));
      check_field("is_alive", 32'(got.is_alive), 32'(want.is_alive));
      check_field("cur_x", 32'(got.cur_x), 32'(want.cur_x));
      check_field("cur_y", 32'(got.cur_y), 32'(want.cur_y));
      check_field("cur_kind", 32'(got.cur_kind), 32'(want.cur_kind));
      check_field("sprite_src_x", 32'(got.sprite_src_x), 32'(want.sprite_src_x));
      check_field("sprite_src_y", 32'(got.sprite_src_y), 32'(want.sprite_src_y));
      check_field("sprite_size", 32'(got.sprite_size), 32'(want.sprite_size));
    end
  endtask

  // Track register writes, results and requests at each edge
  always @(posedge clk_i or negedge rst_ni) begin : track_pool
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SIZE; i++) live_mem[i] = 1'b0;
      gravity   = GRAV_RESET;
      kill_line = KILL_RESET;
      due_results.delete();
      written   = 0;
      due_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_GRAVITY) gravity = cfg_data_i[GRAV_W-1:0];
        else if (cfg_index_i == REG_KILL) kill_line = cfg_data_i[KILL_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready)
        compare_result(out_word_t'(m_axis_tdata[OUT_W-1:0]));
      if (s_axis_tvalid && s_axis_tready)
        apply_request(kind_e'(s_axis_tuser), in_word_t'(s_axis_tdata[IN_W-1:0]));
      due_count = due_results.size();
    end
  end

endmodule

>>> bench/particle_pool_update_tb.sv
// Top of the particle pool update bench: clock, reset, request and register
// stimulus, result backpressure and the verdict. Uses ppu_pkg, the block and
// particle_pool_update_checker.
`timescale 1ns / 100ps

module particle_pool_update_tb;
  import ppu_pkg::*;

  localparam int POOL_SIZE = 512;
  // Quiet limit: must stay well above the slowest quiet stretch, a full-pool
  // tick plus a result stall plus a long request gap.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 600;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  logic [31:0] mismatches;
  logic [31:0] results_due;
  logic [31:0] slots_written;

  int quiet_cycles = 0;
  int hold_off_asked = 0;
  int kill_px = 480;
  bit steady = 1'b0;
  bit fill_style = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  particle_pool_update #(.POOL_SIZE(POOL_SIZE)) dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  particle_pool_update_checker #(.POOL_SIZE(POOL_SIZE)) pool_checker (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(mismatches), .pending_o(results_due), .written_o(slots_written)
  );

  // End the run when no channel moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("particle_pool_update: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result backpressure: random stalls, ready stretches, and requested hold-offs
  initial begin : receiver
    int holds_done;
    int r;
    int span;
    holds_done = 0;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (holds_done != hold_off_asked) begin
        holds_done = hold_off_asked;
        m_axis_tready <= 1'b0;
        span = HOLD_OFF_CYCLES;
      end else if (r < 55) begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 16);
      end else if (r < 70) begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(100, 300);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        m_axis_tready <= 1'b0;
        span = $urandom_range(20, 200);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  function automatic int signed_near(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random content in every field; the kind decides which ones matter
  function automatic in_word_t noise_word();
    in_word_t w;
    w.spawn_x    = POS_W'($urandom);
    w.spawn_y    = POS_W'($urandom);
    w.spawn_vx   = VEL_W'($urandom);
    w.spawn_vy   = VEL_W'($urandom);
    w.spawn_kind = 1'($urandom);
    w.slot_index = SLOT_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t spawn_word(input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y,
                                          input logic [VEL_W-1:0] vx,
                                          input logic [VEL_W-1:0] vy,
                                          input logic big);
    in_word_t w;
    w = noise_word();
    w.spawn_x    = x;
    w.spawn_y    = y;
    w.spawn_vx   = vx;
    w.spawn_vy   = vy;
    w.spawn_kind = big;
    return w;
  endfunction

  // Mostly start near the kill line so particles live a while and then die
  function automatic in_word_t random_spawn();
    in_word_t w;
    w = noise_word();
    if ($urandom_range(0, 9) < 7) w.spawn_x = POS_W'(signed_near(1000 * 256));
    if ($urandom_range(0, 9) < 7) w.spawn_vx = VEL_W'(signed_near(2048));
    if (fill_style) begin
      w.spawn_y  = POS_W'(-int'($urandom_range(0, 2048)));
      w.spawn_vy = VEL_W'($urandom_range(0, 32767));
    end else begin
      if ($urandom_range(0, 4) != 0)
        w.spawn_y = POS_W'(kill_px * 256 + int'($urandom_range(0, 72 * 256)) - 64 * 256);
      if ($urandom_range(0, 9) < 7) w.spawn_vy = VEL_W'(signed_near(1024));
    end
    return w;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input kind_e kind, input in_word_t w);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(30, 120);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, w};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic read_slot(input int idx);
    in_word_t w;
    w = noise_word();
    w.slot_index = SLOT_W'(idx);
    send_request(KIND_READ, w);
  endtask

  task automatic random_request(input int spawn_pct, input int tick_pct);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) steady = !steady;
    if (r < 2) send_request(KIND_NONE, noise_word());
    else if (r < 2 + spawn_pct || slots_written == 0) send_request(KIND_SPAWN, random_spawn());
    else if (r < 2 + spawn_pct + tick_pct) send_request(KIND_TICK, noise_word());
    else read_slot($urandom_range(0, slots_written - 1));
  endtask

  // Stop offering, wait for every result, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_due != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Saturating corners: x, vx, vy at the top and y at the bottom, then x, vx, vy at the bottom and y at zero
    send_request(KIND_SPAWN, spawn_word(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h7FFF, 1'b1));
    send_request(KIND_SPAWN, spawn_word(24'h800000, 24'h000000, 16'h8000, 16'h8000, 1'b0));
    // One gravity step short of the kill line: lands on it, dies a tick later
    send_request(KIND_SPAWN, spawn_word(24'h0, 24'd122778, 16'h0, 16'h0, 1'b0));
    // Already on the kill line: dies on the first tick
    send_request(KIND_SPAWN, spawn_word(24'h0, 24'd122880, 16'h0, 16'h0, 1'b1));
    send_request(KIND_NONE, noise_word());
    read_slot(0);
    send_request(KIND_TICK, noise_word());
    read_slot(2);
    read_slot(3);
    // Reuse the freed slot, then read a dead one
    send_request(KIND_SPAWN, spawn_word(24'h0, 24'h0, 16'h0, 16'hFF00, 1'b1));
    send_request(KIND_TICK, noise_word());
    read_slot(2);
    // Walk the frame counter to its last frame and across the wrap
    repeat (5) send_request(KIND_TICK, noise_word());
    read_slot(0);
    send_request(KIND_TICK, noise_word());
    read_slot(0);
    read_slot(1);
    read_slot(3);

    // Strongest gravity, lowest kill line; block stalls under a long hold-off
    write_register(REG_GRAVITY, 12'd1023);
    write_register(REG_KILL, 12'd4095);
    kill_px = 4095;
    hold_off_asked++;
    repeat (250) random_request(45, 15);

    // No gravity, kill line at the top
    write_register(REG_GRAVITY, 12'd0);
    write_register(REG_KILL, 12'd0);
    kill_px = 0;
    repeat (200) random_request(45, 15);

    // Fill every slot, read across the pool and spawn into a full pool
    write_register(REG_KILL, 12'd4095);
    kill_px = 4095;
    fill_style = 1'b1;
    repeat (520) send_request(KIND_SPAWN, random_spawn());
    fill_style = 1'b0;
    hold_off_asked++;
    read_slot(slots_written - 1);
    repeat (40) read_slot($urandom_range(0, slots_written - 1));
    repeat (2) send_request(KIND_TICK, noise_word());
    repeat (3) send_request(KIND_SPAWN, random_spawn());

    // Drain the full pool with strong gravity
    write_register(REG_GRAVITY, 12'd1023);
    write_register(REG_KILL, 12'd0);
    kill_px = 0;
    repeat (60) random_request(30, 30);

    // Random settings; gravity data carries junk in its upper bits
    write_register(REG_GRAVITY, CFG_W'($urandom));
    kill_px = $urandom_range(0, 4095);
    write_register(REG_KILL, CFG_W'(kill_px));
    repeat (70) random_request(45, 15);

    settle();
    if (mismatches == 0 && results_due == 0) begin
      $display("particle_pool_update: match");
    end else begin
      $display("particle_pool_update: mismatch");
    end
    $finish;
  end

endmodule
